>>> rtl/tlfor_pkg.sv
// ----------------------------------------------------------------------------
// tlfor_pkg
// Types and constants for the track line fit with outlier rejection.
// ----------------------------------------------------------------------------
package tlfor_pkg;

  typedef enum logic [4:0] {
    S_COLLECT,
    S_UD0, S_UD1, S_UB0, S_UB1,
    S_UND, S_UNB, S_UC0, S_UC1, S_ULIM,
    S_UH0, S_UH1, S_UH2,
    S_WSEL, S_WT, S_WDIV, S_WS,
    S_FD0, S_FD1, S_FB0, S_FB1,
    S_FSL, S_FI0, S_FI1, S_FIC, S_FL2,
    S_RSEL, S_R0, S_R1, S_R2,
    S_DONE
  } state_t;

  localparam logic [1:0] REG_FIRST_LIMIT  = 2'd0;
  localparam logic [1:0] REG_SECOND_LIMIT = 2'd1;

  localparam logic [1:0] FIT_OK        = 2'd0;
  localparam logic [1:0] FIT_UNW_DEGEN = 2'd1;
  localparam logic [1:0] FIT_WGT_DEGEN = 2'd2;

  localparam logic [3:0] FIRST_LIMIT_RST  = 4'd1;
  localparam logic [3:0] SECOND_LIMIT_RST = 4'd5;

  localparam int W_NUM       = 65536000;
  localparam int W_NUM_BITS  = 26;
  localparam int W_BIAS      = 400;
  localparam int WEIGHT_BITS = 18;
  localparam int WDEN_BITS   = 21;
  localparam int Q_FRAC      = 16;
  localparam int HALF_SCALE  = 32768;

endpackage

>>> rtl/track_line_fit_outlier_reject.sv
// ----------------------------------------------------------------------------
// track_line_fit_outlier_reject
// Straight-line fit of eight-hit events with two rounds of outlier rejection.
//
//   channel  dir  ports                        contents
//   in       in   in_tvalid/tready/tdata[15:0] raw hit word
//   out      out  out_tvalid/tready/tdata[79:0] slope, intercept, mask, count,
//                                               status
//   cfg      in   cfg_wen/index/wdata          residual limits
//
// Words are taken one per cycle; after the last word of an event the input
// stalls while a sequencer drives one shared multiplier, accumulator and
// restoring divider (one quotient bit a cycle) through the unweighted stage,
// the weight and sums of each kept hit, the slope and intercept divisions
// and the second residual pass. A finished result waits in the output
// register; the next event's words are collected meanwhile. Reset is
// synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module track_line_fit_outlier_reject import tlfor_pkg::*; #(
  parameter int HITS_PER_EVENT = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // raw_word[15:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // fit_slope[31:0], fit_intercept[63:32], kept_mask[71:64],
  // removed_count[75:72], fit_status[77:76], zero pad
  output logic [79:0] out_tdata,
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_wdata
);

  localparam int CW    = $clog2(HITS_PER_EVENT + 1);
  localparam int IW    = $clog2(HITS_PER_EVENT);
  localparam int USXW  = CW + 3;
  localparam int USYW  = CW + 4;
  localparam int USXXW = CW + 6;
  localparam int USXYW = CW + 7;
  localparam int WW    = WEIGHT_BITS + CW;
  localparam int SXW   = WW + 3;
  localparam int SYW   = WW + 4;
  localparam int SXXW  = WW + 6;
  localparam int SXYW  = WW + 7;
  localparam int MW    = (SXYW + 2 > 33) ? SXYW + 2 : 33;
  localparam int DW    = 2 * MW;
  localparam int DCW   = $clog2(DW + Q_FRAC + 1);
  localparam logic [IW-1:0] LAST = IW'(HITS_PER_EVENT - 1);

  state_t state_r, state_nxt;
  logic            ph_r;
  logic [IW-1:0]   wc_r, i_r;
  logic [1:0]      j_r;
  logic [15:0]     hit_mem_r [HITS_PER_EVENT];
  logic [3:0]      lim1_r, lim2_r;

  logic [USXW-1:0]  usx_r;
  logic [USYW-1:0]  usy_r;
  logic [USXXW-1:0] usxx_r;
  logic [USXYW-1:0] usxy_r;

  logic [WW-1:0]   wsum_r;
  logic [SXW-1:0]  sx_r;
  logic [SYW-1:0]  sy_r;
  logic [SXXW-1:0] sxx_r;
  logic [SXYW-1:0] sxy_r;
  logic [WEIGHT_BITS-1:0] w_r;
  logic [WDEN_BITS-1:0]   wden_r;

  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [DW-1:0] mul_full, mul_p_r, acc_r, acc_sub;
  logic signed [DW-1:0] d_r, bn_r, nd_r, nb_r, c_r, limc_r, lim2c_r;
  logic signed [DW-1:0] slope_r, icpt_r, dv_res;

  logic [DW-1:0]  dv_num_r, dv_den_r, dv_q_r, dv_rem_r;
  logic [DCW-1:0] dv_cnt_r;
  logic           dv_neg_r;
  logic [DW:0]    dv_rem2, dv_remn;
  logic           dv_ge;
  logic [DW-1:0]  bn_mag, acc_mag;

  logic [HITS_PER_EVENT-1:0] keep_r;
  logic [CW-1:0]   rem_cnt_r;
  logic [1:0]      status_r;

  logic            out_tvalid_r;
  logic [31:0]     o_slope_r, o_icpt_r;
  logic [7:0]      o_mask_r;
  logic [3:0]      o_rem_r;
  logic [1:0]      o_status_r;

  logic [15:0] cur;
  logic [2:0]  cx, ix;
  logic [3:0]  cy2, iy2;
  logic [9:0]  ct;
  logic [5:0]  cxx, ixx;
  logic [6:0]  cxy, ixy;
  logic        i_last, out_free, is_div;

  assign cur = hit_mem_r[i_r];
  assign cx  = cur[15:13];
  assign cy2 = {cur[12:10], cur[13]};
  assign ct  = cur[9:0];
  assign cxx = {3'b0, cx} * {3'b0, cx};
  assign cxy = {4'b0, cx} * {3'b0, cy2};
  assign ix  = in_tdata[15:13];
  assign iy2 = {in_tdata[12:10], in_tdata[13]};
  assign ixx = {3'b0, ix} * {3'b0, ix};
  assign ixy = {4'b0, ix} * {3'b0, iy2};

  assign i_last   = (i_r == LAST);
  assign out_free = !out_tvalid_r || out_tready;
  assign is_div   = (state_r == S_WDIV) || (state_r == S_FSL) || (state_r == S_FIC);

  assign mul_full = mul_a * mul_b;
  assign acc_sub  = acc_r - mul_p_r;

  assign dv_rem2 = {dv_rem_r, dv_num_r[DW-1]};
  assign dv_ge   = (dv_rem2 >= {1'b0, dv_den_r});
  assign dv_remn = dv_ge ? dv_rem2 - {1'b0, dv_den_r} : dv_rem2;
  assign dv_res  = dv_neg_r ? -$signed(dv_q_r) : $signed(dv_q_r);
  assign bn_mag  = bn_r[DW-1] ? -bn_r : bn_r;
  assign acc_mag = acc_r[DW-1] ? -acc_r : acc_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_COLLECT: if (in_tvalid && wc_r == LAST) state_nxt = S_UD0;
      S_UD0:     if (ph_r) state_nxt = S_UD1;
      S_UD1:     if (ph_r) state_nxt = S_UB0;
      S_UB0:     if (ph_r) state_nxt = S_UB1;
      S_UB1:     if (ph_r) state_nxt = (d_r == '0) ? S_WSEL : S_UND;
      S_UND:     if (ph_r) state_nxt = S_UNB;
      S_UNB:     if (ph_r) state_nxt = S_UC0;
      S_UC0:     if (ph_r) state_nxt = S_UC1;
      S_UC1:     if (ph_r) state_nxt = S_ULIM;
      S_ULIM:    if (ph_r) state_nxt = S_UH0;
      S_UH0:     if (ph_r) state_nxt = S_UH1;
      S_UH1:     if (ph_r) state_nxt = S_UH2;
      S_UH2:     state_nxt = i_last ? S_WSEL : S_UH0;
      S_WSEL:    state_nxt = keep_r[i_r] ? S_WT : (i_last ? S_FD0 : S_WSEL);
      S_WT:      if (ph_r) state_nxt = S_WDIV;
      S_WDIV:    if (ph_r && dv_cnt_r == '0) state_nxt = S_WS;
      S_WS:      if (ph_r && j_r == 2'd3) state_nxt = i_last ? S_FD0 : S_WSEL;
      S_FD0:     if (ph_r) state_nxt = S_FD1;
      S_FD1:     if (ph_r) state_nxt = S_FB0;
      S_FB0:     if (ph_r) state_nxt = S_FB1;
      S_FB1: begin
        if (ph_r) begin
          state_nxt = (wsum_r == '0 || d_r[DW-1] || d_r == '0) ? S_DONE : S_FSL;
        end
      end
      S_FSL:     if (ph_r && dv_cnt_r == '0) state_nxt = S_FI0;
      S_FI0:     if (ph_r) state_nxt = S_FI1;
      S_FI1:     if (ph_r) state_nxt = S_FIC;
      S_FIC:     if (ph_r && dv_cnt_r == '0) state_nxt = S_FL2;
      S_FL2:     state_nxt = S_RSEL;
      S_RSEL:    state_nxt = keep_r[i_r] ? S_R0 : (i_last ? S_DONE : S_RSEL);
      S_R0:      if (ph_r) state_nxt = S_R1;
      S_R1:      if (ph_r) state_nxt = S_R2;
      S_R2:      state_nxt = i_last ? S_DONE : S_RSEL;
      S_DONE:    if (out_free) state_nxt = S_COLLECT;
      default:   state_nxt = S_COLLECT;
    endcase
  end

  // outputs and multiplier operands
  always_comb begin
    in_tready = (state_r == S_COLLECT);
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_UD0:  begin mul_a = MW'(HITS_PER_EVENT); mul_b = MW'(usxx_r); end
      S_UD1:  begin mul_a = MW'(usx_r);          mul_b = MW'(usx_r);  end
      S_UB0:  begin mul_a = MW'(HITS_PER_EVENT); mul_b = MW'(usxy_r); end
      S_UB1:  begin mul_a = MW'(usx_r);          mul_b = MW'(usy_r);  end
      S_UND:  begin mul_a = MW'(HITS_PER_EVENT); mul_b = MW'(d_r);    end
      S_UNB:  begin mul_a = MW'(HITS_PER_EVENT); mul_b = MW'(bn_r);   end
      S_UC0:  begin mul_a = MW'(d_r);            mul_b = MW'(usy_r);  end
      S_UC1:  begin mul_a = MW'(bn_r);           mul_b = MW'(usx_r);  end
      S_ULIM: begin mul_a = MW'(nd_r);           mul_b = MW'(lim1_r); end
      S_UH0:  begin mul_a = MW'(nd_r);           mul_b = MW'(cy2);    end
      S_UH1:  begin mul_a = MW'(nb_r);           mul_b = MW'(cx);     end
      S_WT:   begin mul_a = MW'(ct);             mul_b = MW'(ct);     end
      S_WS: begin
        mul_a = MW'(w_r);
        case (j_r)
          2'd0:    mul_b = MW'(cx);
          2'd1:    mul_b = MW'(cy2);
          2'd2:    mul_b = MW'(cxx);
          default: mul_b = MW'(cxy);
        endcase
      end
      S_FD0:  begin mul_a = MW'(wsum_r);  mul_b = MW'(sxx_r);      end
      S_FD1:  begin mul_a = MW'(sx_r);    mul_b = MW'(sx_r);       end
      S_FB0:  begin mul_a = MW'(wsum_r);  mul_b = MW'(sxy_r);      end
      S_FB1:  begin mul_a = MW'(sx_r);    mul_b = MW'(sy_r);       end
      S_FI0:  begin mul_a = MW'(sy_r);    mul_b = MW'(HALF_SCALE); end
      S_FI1:  begin mul_a = MW'(slope_r); mul_b = MW'(sx_r);       end
      S_R0:   begin mul_a = MW'(cy2);     mul_b = MW'(HALF_SCALE); end
      S_R1:   begin mul_a = MW'(slope_r); mul_b = MW'(cx);         end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p_r <= mul_full;
    if (!rst_n) begin
      state_r      <= S_COLLECT;
      ph_r         <= 1'b0;
      wc_r         <= '0;
      i_r          <= '0;
      j_r          <= '0;
      dv_cnt_r     <= '0;
      out_tvalid_r <= 1'b0;
      lim1_r       <= FIRST_LIMIT_RST;
      lim2_r       <= SECOND_LIMIT_RST;
    end else begin
      state_r <= state_nxt;
      if (state_nxt != state_r) ph_r <= 1'b0;
      else if (is_div)          ph_r <= 1'b1;
      else                      ph_r <= !ph_r;

      if (cfg_wen) begin
        unique case (cfg_index)
          REG_FIRST_LIMIT:  lim1_r <= cfg_wdata;
          REG_SECOND_LIMIT: lim2_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (dv_cnt_r != '0) begin
        dv_rem_r <= dv_remn[DW-1:0];
        dv_num_r <= dv_num_r << 1;
        dv_q_r   <= {dv_q_r[DW-2:0], dv_ge};
        dv_cnt_r <= dv_cnt_r - 1'b1;
      end

      if (state_r == S_DONE && out_free) out_tvalid_r <= 1'b1;
      else if (out_tready)               out_tvalid_r <= 1'b0;

      case (state_r)
        S_COLLECT: begin
          if (in_tvalid) begin
            hit_mem_r[wc_r] <= in_tdata;
            wc_r <= (wc_r == LAST) ? '0 : wc_r + 1'b1;
            if (wc_r == '0) begin
              usx_r  <= USXW'(ix);
              usy_r  <= USYW'(iy2);
              usxx_r <= USXXW'(ixx);
              usxy_r <= USXYW'(ixy);
            end else begin
              usx_r  <= usx_r + USXW'(ix);
              usy_r  <= usy_r + USYW'(iy2);
              usxx_r <= usxx_r + USXXW'(ixx);
              usxy_r <= usxy_r + USXYW'(ixy);
            end
            if (wc_r == LAST) begin
              keep_r    <= '1;
              status_r  <= FIT_OK;
              rem_cnt_r <= '0;
              wsum_r    <= '0;
              sx_r      <= '0;
              sy_r      <= '0;
              sxx_r     <= '0;
              sxy_r     <= '0;
              i_r       <= '0;
              j_r       <= '0;
            end
          end
        end
        S_UD0, S_UB0, S_UC0, S_UH0, S_FD0, S_FB0, S_FI0, S_R0: begin
          if (ph_r) acc_r <= mul_p_r;
        end
        S_UH1, S_FI1, S_R1: if (ph_r) acc_r <= acc_sub;
        S_UD1, S_FD1:       if (ph_r) d_r <= acc_sub;
        S_UB1: begin
          if (ph_r) begin
            bn_r <= acc_sub;
            if (d_r == '0) begin
              status_r <= FIT_UNW_DEGEN;
              i_r      <= '0;
            end
          end
        end
        S_UND: if (ph_r) nd_r <= mul_p_r;
        S_UNB: if (ph_r) nb_r <= mul_p_r;
        S_UC1: if (ph_r) c_r <= acc_sub;
        S_ULIM: begin
          if (ph_r) begin
            limc_r <= (mul_p_r <<< 1) + c_r;
            i_r    <= '0;
          end
        end
        S_UH2: begin
          if (acc_r > limc_r) keep_r[i_r] <= 1'b0;
          i_r <= i_last ? '0 : i_r + 1'b1;
        end
        S_WSEL: begin
          j_r <= '0;
          if (!keep_r[i_r]) i_r <= i_last ? '0 : i_r + 1'b1;
        end
        S_WT: if (ph_r) wden_r <= mul_p_r[WDEN_BITS-1:0] + WDEN_BITS'(W_BIAS);
        S_WDIV: begin
          if (!ph_r) begin
            dv_num_r <= DW'(W_NUM) << (DW - W_NUM_BITS);
            dv_den_r <= DW'(wden_r);
            dv_rem_r <= '0;
            dv_q_r   <= '0;
            dv_neg_r <= 1'b0;
            dv_cnt_r <= DCW'(W_NUM_BITS);
          end else if (dv_cnt_r == '0) begin
            w_r <= dv_q_r[WEIGHT_BITS-1:0];
          end
        end
        S_WS: begin
          if (ph_r) begin
            case (j_r)
              2'd0: begin
                sx_r   <= sx_r + SXW'(mul_p_r);
                wsum_r <= wsum_r + WW'(w_r);
              end
              2'd1:    sy_r  <= sy_r + SYW'(mul_p_r);
              2'd2:    sxx_r <= sxx_r + SXXW'(mul_p_r);
              default: sxy_r <= sxy_r + SXYW'(mul_p_r);
            endcase
            j_r <= j_r + 1'b1;
            if (j_r == 2'd3) i_r <= i_last ? '0 : i_r + 1'b1;
          end
        end
        S_FB1: begin
          if (ph_r) begin
            bn_r <= acc_sub;
            if (wsum_r == '0 || d_r[DW-1] || d_r == '0) begin
              if (status_r == FIT_OK) status_r <= FIT_WGT_DEGEN;
              slope_r <= '0;
              icpt_r  <= '0;
            end
          end
        end
        S_FSL: begin
          if (!ph_r) begin
            dv_num_r <= bn_mag;
            dv_den_r <= d_r <<< 1;
            dv_rem_r <= '0;
            dv_q_r   <= '0;
            dv_neg_r <= bn_r[DW-1];
            dv_cnt_r <= DCW'(DW + Q_FRAC);
          end else if (dv_cnt_r == '0) begin
            slope_r <= dv_res;
          end
        end
        S_FIC: begin
          if (!ph_r) begin
            dv_num_r <= acc_mag;
            dv_den_r <= DW'(wsum_r);
            dv_rem_r <= '0;
            dv_q_r   <= '0;
            dv_neg_r <= acc_r[DW-1];
            dv_cnt_r <= DCW'(DW);
          end else if (dv_cnt_r == '0) begin
            icpt_r <= dv_res;
          end
        end
        S_FL2: begin
          lim2c_r <= $signed(DW'({lim2_r, 16'b0})) + icpt_r;
          i_r     <= '0;
        end
        S_RSEL: if (!keep_r[i_r]) i_r <= i_last ? '0 : i_r + 1'b1;
        S_R2: begin
          if (acc_r > lim2c_r) begin
            keep_r[i_r] <= 1'b0;
            rem_cnt_r   <= rem_cnt_r + 1'b1;
          end
          i_r <= i_last ? '0 : i_r + 1'b1;
        end
        S_DONE: begin
          if (out_free) begin
            o_slope_r    <= slope_r[31:0];
            o_icpt_r     <= icpt_r[31:0];
            o_mask_r     <= 8'(keep_r);
            o_rem_r      <= 4'(rem_cnt_r);
            o_status_r   <= status_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, o_status_r, o_rem_r, o_mask_r, o_icpt_r, o_slope_r};

  a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_cnt_r != '0) |-> is_div)
    else $error("divider running outside a division step");

  a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (out_tvalid_r && state_r == S_COLLECT))
    else $error("finished fit not presented");

  a_removed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_COLLECT) |-> (rem_cnt_r <= CW'(HITS_PER_EVENT)))
    else $error("removal count out of range");

  a_keep_only_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_COLLECT && $past(state_r) != S_COLLECT)
      |-> ((keep_r & ~$past(keep_r)) == '0))
    else $error("kept hit restored during fit");

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for track_line_fit_outlier_reject: raw hit words are streamed in
// eight to an event; a behavioural line-fit predictor in the testbench works
// out slope, intercept, kept mask, removal count and status for each event,
// and every result transfer is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top import tlfor_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HITS = 8;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  removed;
    logic [7:0]  mask;
    logic [31:0] icpt;
    logic [31:0] slope;
  } fit_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic        cfg_wen = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [3:0]  cfg_wdata = '0;

  track_line_fit_outlier_reject #(.HITS_PER_EVENT(HITS)) uut (.*);

  always #6 clk = ~clk;

  fit_res_t    fit_queue[$];
  logic [15:0] event_words[HITS];
  int          word_idx = 0;
  logic [3:0]  lim1 = FIRST_LIMIT_RST, lim2 = SECOND_LIMIT_RST;
  int          mismatches = 0, results_seen = 0, events_sent = 0, cycles = 0;
  int          out_idle = 0;
  bit          quiet = 1'b0;

  function automatic longint q16_div(longint num, longint den);
    bit neg;
    longint unsigned mag, q, r;
    neg = num < 0;
    mag = neg ? -num : num;
    q = mag / den;
    r = mag % den;
    for (int k = 0; k < 16; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r -= den;
        q |= 1;
      end
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic fit_res_t predict_fit();
    fit_res_t res;
    bit keep[HITS];
    longint x[HITS], y[HITS], w[HITS];
    longint n, sx, sy, sxx, sxy, d, bn, lhs, wsum, slope, icpt, r;
    longint unsigned t;
    int removed;
    logic [1:0] status;
    n = 0; sx = 0; sy = 0; sxx = 0; sxy = 0; slope = 0; icpt = 0;
    removed = 0; status = FIT_OK;
    for (int i = 0; i < HITS; i++) begin
      x[i] = event_words[i][15:13];
      y[i] = 2 * event_words[i][12:10] + event_words[i][13];
      t = event_words[i][9:0];
      w[i] = 65536000 / (400 + t * t);
      keep[i] = 1'b1;
      n++; sx += x[i]; sy += y[i]; sxx += x[i] * x[i]; sxy += x[i] * y[i];
    end
    d = n * sxx - sx * sx;
    bn = n * sxy - sx * sy;
    if (d == 0) status = FIT_UNW_DEGEN;
    else
      for (int i = 0; i < HITS; i++) begin
        lhs = n * d * y[i] - n * bn * x[i] - (d * sy - bn * sx);
        if (lhs > 2 * n * d * longint'(lim1)) keep[i] = 1'b0;
      end
    wsum = 0; sx = 0; sy = 0; sxx = 0; sxy = 0;
    for (int i = 0; i < HITS; i++)
      if (keep[i]) begin
        wsum += w[i]; sx += w[i] * x[i]; sy += w[i] * y[i];
        sxx += w[i] * x[i] * x[i]; sxy += w[i] * x[i] * y[i];
      end
    d = wsum * sxx - sx * sx;
    bn = wsum * sxy - sx * sy;
    if (wsum <= 0 || d <= 0) begin
      if (status == FIT_OK) status = FIT_WGT_DEGEN;
    end else begin
      slope = q16_div(bn, 2 * d);
      icpt = (sy * 32768 - slope * sx) / wsum;
      for (int i = 0; i < HITS; i++)
        if (keep[i]) begin
          r = y[i] * 32768 - slope * x[i] - icpt;
          if (r > longint'(lim2) * 65536) begin
            keep[i] = 1'b0;
            removed++;
          end
        end
    end
    res.slope = slope[31:0];
    res.icpt = icpt[31:0];
    for (int i = 0; i < 8; i++) res.mask[i] = keep[i];
    res.removed = removed[3:0];
    res.status = status;
    return res;
  endfunction

  task automatic send_word(input logic [15:0] word);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    event_words[word_idx] = word;
    word_idx++;
    if (word_idx == HITS) begin
      word_idx = 0;
      fit_queue = {fit_queue, predict_fit()};
      events_sent++;
    end
  endtask

  // event on a line y = y0 + k*x/2 with small scatter, a few outliers
  task automatic send_track_event();
    int y0, k, yv;
    logic [2:0] xv;
    y0 = $urandom_range(0, 7);
    k = int'($urandom_range(0, 2)) - 1;
    for (int i = 0; i < HITS; i++) begin
      xv = $urandom_range(0, 7);
      yv = y0 + (k * int'(xv)) / 2 + (int'($urandom_range(0, 2)) - 1);
      if ($urandom_range(0, 5) == 0) yv = $urandom_range(0, 7);
      if (yv < 0) yv = 0;
      if (yv > 7) yv = 7;
      send_word({xv, yv[2:0], 10'($urandom_range(0, 1023))});
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    if (idx == REG_FIRST_LIMIT) lim1 = val;
    else if (idx == REG_SECOND_LIMIT) lim2 = val;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (fit_queue.size() != 0) @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [15:0] w;
    for (int i = 0; i < HITS; i++) send_word({3'd2, 3'($urandom), 10'(i * 100)});
    for (int i = 0; i < HITS; i++) send_word({3'(i), 3'(i / 2), 10'd0});
    for (int i = 0; i < HITS; i++) begin
      w = (i < 4) ? 16'h0000 : 16'hFFFF;
      send_word(w);
    end
    for (int i = 0; i < HITS; i++) send_word({3'(i), (i == 3) ? 3'd7 : 3'd0, 10'd1023});
    wait_drained();
  endtask

  task automatic test_limits();
    write_reg(REG_FIRST_LIMIT, 4'd0);
    write_reg(REG_SECOND_LIMIT, 4'd0);
    write_reg(2'd3, 4'd9);
    repeat (4) send_track_event();
    wait_drained();
    write_reg(REG_FIRST_LIMIT, 4'd15);
    write_reg(REG_SECOND_LIMIT, 4'd15);
    repeat (4) send_track_event();
    wait_drained();
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(REG_FIRST_LIMIT, 4'($urandom_range(0, 15)));
      write_reg(REG_SECOND_LIMIT, 4'($urandom_range(0, 15)));
      quiet = (phase == 3);
      for (int e = 0; e < 17; e++)
        if ($urandom_range(0, 3) == 0)
          for (int i = 0; i < HITS; i++) send_word(16'($urandom));
        else send_track_event();
      wait_drained();
    end
  endtask

  // result side: random stall bursts and field-wise check
  always @(posedge clk) begin
    fit_res_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[77:0];
        results_seen++;
        if (fit_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer %h", out_tdata);
        end else begin
          want = fit_queue.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"event %0d: exp slope %h icpt %h mask %h rem %0d st %0d, ",
                        "got %h %h %h %0d %0d"},
                       results_seen, want.slope, want.icpt, want.mask, want.removed,
                       want.status, got.slope, got.icpt, got.mask, got.removed, got.status);
          end
        end
      end
      if (out_idle > 0) begin
        out_idle--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_idle = $urandom_range(0, 4);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_limits();
    test_random();
    $display("%0d events, %0d results checked over several limit settings, %0d mismatches",
             events_sent, results_seen, mismatches);
    if (mismatches == 0 && fit_queue.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
